[rtl/assert_macros.svh]
// Shared assertion helpers, sampled on i_clk and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SHA1_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SHA1_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/sha1_pkg.sv]
package sha1_pkg;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } t_vars;

    typedef struct packed {
        logic       load_byte;
        logic       shift_word;
        logic [7:0] byte_val;
    } t_sched_ctrl;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // round groups of twenty
    localparam logic [1:0] STG_CH   = 2'd0;
    localparam logic [1:0] STG_PAR1 = 2'd1;
    localparam logic [1:0] STG_MAJ  = 2'd2;
    localparam logic [1:0] STG_PAR2 = 2'd3;

    localparam logic [6:0] LAST_ROUND = 7'd79;

    function automatic logic [31:0] k_for(input logic [1:0] stg);
        logic [31:0] k;
        case (stg)
            STG_CH:   k = K0;
            STG_PAR1: k = K1;
            STG_MAJ:  k = K2;
            default:  k = K3;
        endcase
        return k;
    endfunction

endpackage

[rtl/sha1_round.sv]
module sha1_round (
    input  sha1_pkg::t_vars i_vars,
    input  logic [31:0]     i_w,
    input  logic [6:0]      i_rnd,
    output sha1_pkg::t_vars o_vars
);

    logic [1:0]  stg;
    logic [31:0] f;
    logic [31:0] tmp;

    always_comb begin
        if (i_rnd < 7'd20) begin
            stg = sha1_pkg::STG_CH;
        end else if (i_rnd < 7'd40) begin
            stg = sha1_pkg::STG_PAR1;
        end else if (i_rnd < 7'd60) begin
            stg = sha1_pkg::STG_MAJ;
        end else begin
            stg = sha1_pkg::STG_PAR2;
        end
    end

    always_comb begin
        case (stg)
            sha1_pkg::STG_CH: begin
                f = (i_vars.b & i_vars.c) | (~i_vars.b & i_vars.d);
            end
            sha1_pkg::STG_MAJ: begin
                f = (i_vars.b & i_vars.c) | (i_vars.b & i_vars.d) | (i_vars.c & i_vars.d);
            end
            default: begin
                f = i_vars.b ^ i_vars.c ^ i_vars.d;
            end
        endcase
    end

    assign tmp = {i_vars.a[26:0], i_vars.a[31:27]} + f + i_vars.e + i_w
               + sha1_pkg::k_for(stg);

    assign o_vars = '{a: tmp,
                      b: i_vars.a,
                      c: {i_vars.b[1:0], i_vars.b[31:2]},
                      d: i_vars.c,
                      e: i_vars.d};

endmodule

[rtl/sha1_msg_sched.sv]
module sha1_msg_sched (
    input  logic                  i_clk,
    input  sha1_pkg::t_sched_ctrl i_ctrl,
    output logic [31:0]           o_w
);

    // 64-byte block, byte 0 at the top. During compression the same
    // register is the 16-word schedule window, word 0 being W[t].
    logic [511:0] r_blk;
    logic [31:0]  w_new;
    logic [31:0]  w_mix;

    assign w_mix = r_blk[95:64] ^ r_blk[255:224] ^ r_blk[447:416] ^ r_blk[511:480];
    assign w_new = {w_mix[30:0], w_mix[31]};
    assign o_w   = r_blk[511:480];

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_byte) begin
            r_blk <= {r_blk[503:0], i_ctrl.byte_val};
        end else if (i_ctrl.shift_word) begin
            r_blk <= {r_blk[479:0], w_new};
        end
    end

endmodule

[rtl/sha1_hash_engine.sv]
// Byte without end mark: taken while idle; ready again the next cycle unless it completes a block.
// A byte that completes a block keeps the engine busy through the rounds and the add.
// End mark: one pad byte per cycle outside compression (9 to 72 pad bytes), each padded block
// compressed as above, then five digest words, one per cycle when the sink does not stall.
// Reset is synchronous, active low: counters cleared, chaining value set to
// the initial words; block buffer and round variables are left unset.
module sha1_hash_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word,
    output logic        o_length_overflow
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PAD  = 3'd1;
    localparam logic [2:0] ST_COMP = 3'd2;
    localparam logic [2:0] ST_ADD  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    localparam logic [1:0] PH_MARK = 2'd0;
    localparam logic [1:0] PH_ZERO = 2'd1;
    localparam logic [1:0] PH_LEN  = 2'd2;

    localparam logic [2:0] LAST_IDX = 3'd4;

    logic [2:0]  r_state, n_state;
    logic [5:0]  r_cnt, n_cnt;
    logic [63:0] r_bitlen, n_bitlen;
    logic        r_ovf, n_ovf;
    logic [31:0] r_chain [5];
    logic [31:0] n_chain [5];
    sha1_pkg::t_vars r_vars, n_vars;
    logic [6:0]  r_rnd, n_rnd;
    logic [1:0]  r_ph, n_ph;
    logic        r_pad, n_pad;
    logic        r_fin, n_fin;
    logic [2:0]  r_oidx, n_oidx;

    logic                  accept_in;
    logic                  out_acc;
    logic                  absorb;
    logic [7:0]            abs_byte;
    logic [31:0]           w_cur;
    sha1_pkg::t_vars       rnd_out;
    sha1_pkg::t_sched_ctrl sched_ctrl;

    assign o_stall   = (r_state != ST_IDLE);
    assign o_valid   = (r_state == ST_OUT);
    assign accept_in = i_valid && !o_stall;
    assign out_acc   = o_valid && !i_stall;

    sha1_msg_sched u_sched (
        .i_clk  (i_clk),
        .i_ctrl (sched_ctrl),
        .o_w    (w_cur)
    );

    sha1_round u_round (
        .i_vars (r_vars),
        .i_w    (w_cur),
        .i_rnd  (r_rnd),
        .o_vars (rnd_out)
    );

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_bitlen = r_bitlen;
        n_ovf    = r_ovf;
        n_chain  = r_chain;
        n_vars   = r_vars;
        n_rnd    = r_rnd;
        n_ph     = r_ph;
        n_pad    = r_pad;
        n_fin    = r_fin;
        n_oidx   = r_oidx;
        absorb   = 1'b0;
        abs_byte = i_data_byte;
        sched_ctrl.shift_word = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (accept_in) begin
                    if (i_has_byte) begin
                        absorb   = 1'b1;
                        n_bitlen = r_bitlen + 64'd8;
                        if (n_bitlen == 64'd0) begin
                            n_ovf = 1'b1;
                        end
                    end
                    if (i_last_byte) begin
                        n_pad   = 1'b1;
                        n_ph    = PH_MARK;
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                absorb = 1'b1;
                case (r_ph)
                    PH_MARK: begin
                        abs_byte = sha1_pkg::PAD_BYTE;
                        n_ph     = PH_ZERO;
                    end
                    PH_ZERO: begin
                        if (r_cnt == 6'd56) begin
                            abs_byte = r_bitlen[63:56];
                            n_bitlen = {r_bitlen[55:0], 8'h00};
                            n_ph     = PH_LEN;
                        end else begin
                            abs_byte = 8'h00;
                        end
                    end
                    default: begin
                        abs_byte = r_bitlen[63:56];
                        n_bitlen = {r_bitlen[55:0], 8'h00};
                        if (r_cnt == 6'd63) begin
                            n_fin = 1'b1;
                            n_pad = 1'b0;
                        end
                    end
                endcase
            end
            ST_COMP: begin
                sched_ctrl.shift_word = 1'b1;
                n_vars = rnd_out;
                n_rnd  = r_rnd + 7'd1;
                if (r_rnd == sha1_pkg::LAST_ROUND) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                n_chain[0] = r_chain[0] + r_vars.a;
                n_chain[1] = r_chain[1] + r_vars.b;
                n_chain[2] = r_chain[2] + r_vars.c;
                n_chain[3] = r_chain[3] + r_vars.d;
                n_chain[4] = r_chain[4] + r_vars.e;
                if (r_fin) begin
                    n_state = ST_OUT;
                    n_oidx  = 3'd0;
                end else if (r_pad) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (out_acc) begin
                    if (r_oidx == LAST_IDX) begin
                        n_state    = ST_IDLE;
                        n_chain[0] = sha1_pkg::IV0;
                        n_chain[1] = sha1_pkg::IV1;
                        n_chain[2] = sha1_pkg::IV2;
                        n_chain[3] = sha1_pkg::IV3;
                        n_chain[4] = sha1_pkg::IV4;
                        n_cnt      = 6'd0;
                        n_bitlen   = 64'd0;
                        n_ovf      = 1'b0;
                        n_fin      = 1'b0;
                        n_pad      = 1'b0;
                        n_oidx     = 3'd0;
                    end else begin
                        n_oidx = r_oidx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // a full block kicks off compression from the current chaining value
        if (absorb) begin
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd63) begin
                n_state = ST_COMP;
                n_rnd   = 7'd0;
                n_vars  = '{a: r_chain[0], b: r_chain[1], c: r_chain[2],
                            d: r_chain[3], e: r_chain[4]};
            end
        end

        sched_ctrl.load_byte = absorb;
        sched_ctrl.byte_val  = abs_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_cnt      <= 6'd0;
            r_bitlen   <= 64'd0;
            r_ovf      <= 1'b0;
            r_chain[0] <= sha1_pkg::IV0;
            r_chain[1] <= sha1_pkg::IV1;
            r_chain[2] <= sha1_pkg::IV2;
            r_chain[3] <= sha1_pkg::IV3;
            r_chain[4] <= sha1_pkg::IV4;
            r_rnd      <= 7'd0;
            r_ph       <= PH_MARK;
            r_pad      <= 1'b0;
            r_fin      <= 1'b0;
            r_oidx     <= 3'd0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_bitlen <= n_bitlen;
            r_ovf    <= n_ovf;
            r_chain  <= n_chain;
            r_rnd    <= n_rnd;
            r_ph     <= n_ph;
            r_pad    <= n_pad;
            r_fin    <= n_fin;
            r_oidx   <= n_oidx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vars <= n_vars;
    end

    always_comb begin
        case (r_oidx)
            3'd0:    o_digest_word = r_chain[0];
            3'd1:    o_digest_word = r_chain[1];
            3'd2:    o_digest_word = r_chain[2];
            3'd3:    o_digest_word = r_chain[3];
            default: o_digest_word = r_chain[4];
        endcase
    end

    assign o_word_index      = r_oidx;
    assign o_last_word       = (r_oidx == LAST_IDX);
    assign o_length_overflow = r_ovf;

endmodule

[rtl/sha1_checker.sv]
`include "assert_macros.svh"

module sha1_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_digest_word,
    input logic [2:0]  o_word_index,
    input logic        o_last_word
);

    // no new byte taken while the digest is going out
    `SHA1_ASSERT_IMP(a_busy_out, o_valid, o_stall, "input ready during digest output")

    `SHA1_ASSERT_IMP(a_last_idx, o_valid, o_last_word == (o_word_index == 3'd4), "last flag off index four")

    `SHA1_ASSERT_NXT(a_idx_step, o_valid && !i_stall && !o_last_word, o_valid && (o_word_index == $past(o_word_index) + 3'd1), "digest words out of order")

    `SHA1_ASSERT_NXT(a_hold, o_valid && i_stall, o_valid && $stable(o_digest_word) && $stable(o_word_index), "stalled word changed")

endmodule

bind sha1_hash_engine sha1_checker u_sha1_checker (.*);
